// ===== rtl/core/stkrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stkrm_pkg
// Shared types and constants for the byte stack with remove-by-value.
// ----------------------------------------------------------------------------
package stkrm_pkg;

    localparam int unsigned DEPTH_DEFAULT = 32;
    localparam int unsigned VALUE_W       = 8;
    localparam int unsigned COUNT_W       = 6;
    localparam int unsigned S_TDATA_W     = 16;
    localparam int unsigned M_TDATA_W     = 24;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_REMOVE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // operation broadcast along the row of cells
    typedef struct packed {
        logic push;
        logic pop;
        logic remove;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/stkrm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stkrm_cell
// One stack position: a byte and an occupied flag. Takes the word from the
// cell above on push, from the cell below on pop or on a remove at or above.
// ----------------------------------------------------------------------------
module stkrm_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  stkrm_pkg::cell_ctrl_t             ctrl,
    input  logic [stkrm_pkg::VALUE_W-1:0]     key,
    input  logic [stkrm_pkg::VALUE_W-1:0]     above_data,
    input  logic                              above_valid,
    input  logic [stkrm_pkg::VALUE_W-1:0]     below_data,
    input  logic                              below_valid,
    input  logic                              hit_in,
    output logic                              hit_out,
    output logic [stkrm_pkg::VALUE_W-1:0]     data_out,
    output logic                              valid_out
);

    logic [stkrm_pkg::VALUE_W-1:0] data_reg;
    logic [stkrm_pkg::VALUE_W-1:0] data_next;
    logic                          valid_reg;
    logic                          valid_next;
    logic                          hit_here;

    // first match seen from the top onwards
    assign hit_here = hit_in | (valid_reg & (data_reg == key));
    assign hit_out  = hit_here;

    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctrl.push) begin
            data_next  = above_data;
            valid_next = above_valid;
        end else if (ctrl.pop || (ctrl.remove && hit_here)) begin
            data_next  = below_data;
            valid_next = below_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out  = data_reg;
    assign valid_out = valid_reg;

endmodule

// ===== rtl/core/stack_with_remove_by_value_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_with_remove_by_value_unit
// Byte stack built as a row of shifting cells, top of stack in cell 0.
// Result: registered when the command word is taken, offered the cycle after.
// Throughput: one command per cycle, remove included, unless output stalls;
//   all cells compare and shift together, so the match chain sets the path.
// Reset: synchronous, active low; empties the stack and drops any result.
// ----------------------------------------------------------------------------
module stack_with_remove_by_value_unit #(
    parameter int unsigned DEPTH = stkrm_pkg::DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [1:0] cmd, [9:2] value
    input  logic [stkrm_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] data, [9:8] status, [10] removed, [16:11] count
    output logic [stkrm_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int unsigned FILL_W = $clog2(DEPTH + 1);
    localparam int unsigned VW     = stkrm_pkg::VALUE_W;
    localparam int unsigned CW     = stkrm_pkg::COUNT_W;

    stkrm_pkg::cmd_t        cmd;
    logic [VW-1:0]          value;
    logic                   accept;
    logic                   empty;
    logic                   full;
    logic                   any_hit;
    stkrm_pkg::cell_ctrl_t  ctrl;

    logic [VW-1:0]          cell_data  [DEPTH];
    logic                   cell_valid [DEPTH];
    logic                   cell_hit   [DEPTH];

    logic [FILL_W-1:0]      fill_reg;
    logic [FILL_W-1:0]      fill_next;
    logic                   out_valid_reg;
    logic [VW-1:0]          out_data_reg;
    logic [VW-1:0]          out_data_next;
    stkrm_pkg::status_t     out_status_reg;
    stkrm_pkg::status_t     out_status_next;
    logic                   out_removed_reg;
    logic                   out_removed_next;
    logic [FILL_W+CW-1:0]   count_wide;

    assign cmd    = stkrm_pkg::cmd_t'(s_tdata[1:0]);
    assign value  = s_tdata[VW+1:2];
    assign accept = s_tvalid && s_tready;
    assign empty  = !cell_valid[0];
    assign full   = cell_valid[DEPTH-1];
    assign any_hit = cell_hit[DEPTH-1];

    // result slot frees as it is taken, so a new word may enter alongside
    assign s_tready = !out_valid_reg || m_tready;

    always_comb begin
        ctrl             = '0;
        out_data_next    = '0;
        out_status_next  = stkrm_pkg::ST_OK;
        out_removed_next = 1'b0;
        fill_next        = fill_reg;
        unique case (cmd)
            stkrm_pkg::CMD_PUSH: begin
                if (full) begin
                    out_status_next = stkrm_pkg::ST_FULL;
                end else begin
                    ctrl.push = accept;
                    fill_next = fill_reg + 1'b1;
                end
            end
            stkrm_pkg::CMD_POP: begin
                if (empty) begin
                    out_status_next = stkrm_pkg::ST_EMPTY;
                end else begin
                    ctrl.pop      = accept;
                    out_data_next = cell_data[0];
                    fill_next     = fill_reg - 1'b1;
                end
            end
            stkrm_pkg::CMD_PEEK: begin
                if (empty) begin
                    out_status_next = stkrm_pkg::ST_EMPTY;
                end else begin
                    out_data_next = cell_data[0];
                end
            end
            stkrm_pkg::CMD_REMOVE: begin
                ctrl.remove = accept;
                if (any_hit) begin
                    out_removed_next = 1'b1;
                    fill_next        = fill_reg - 1'b1;
                end
            end
            default: begin
                out_status_next = stkrm_pkg::ST_OK;
            end
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [VW-1:0] above_data;
        logic          above_valid;
        logic [VW-1:0] below_data;
        logic          below_valid;
        logic          hit_in;

        if (i == 0) begin : g_top
            assign above_data  = value;
            assign above_valid = 1'b1;
            assign hit_in      = 1'b0;
        end else begin : g_mid
            assign above_data  = cell_data[i-1];
            assign above_valid = cell_valid[i-1];
            assign hit_in      = cell_hit[i-1];
        end

        if (i == DEPTH - 1) begin : g_bottom
            assign below_data  = '0;
            assign below_valid = 1'b0;
        end else begin : g_inner
            assign below_data  = cell_data[i+1];
            assign below_valid = cell_valid[i+1];
        end

        stkrm_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .key         (value),
            .above_data  (above_data),
            .above_valid (above_valid),
            .below_data  (below_data),
            .below_valid (below_valid),
            .hit_in      (hit_in),
            .hit_out     (cell_hit[i]),
            .data_out    (cell_data[i]),
            .valid_out   (cell_valid[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                fill_reg <= fill_next;
            end
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg    <= out_data_next;
            out_status_reg  <= out_status_next;
            out_removed_reg <= out_removed_next;
        end
    end

    // count reports the low bits of the fill level
    assign count_wide = {{CW{1'b0}}, fill_reg};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(stkrm_pkg::M_TDATA_W - VW - 2 - 1 - CW){1'b0}},
                       count_wide[CW-1:0], out_removed_reg, out_status_reg,
                       out_data_reg};

endmodule

// ===== rtl/core/stkrm_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stkrm_chk
// Port-level checks for the byte stack, bound to the top level.
// ----------------------------------------------------------------------------
module stkrm_chk #(
    parameter int unsigned DEPTH = stkrm_pkg::DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [stkrm_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [stkrm_pkg::M_TDATA_W-1:0]   m_tdata
);

    // a waiting result word holds until taken
    property p_hold;
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata));
    endproperty
    a_hold: assert property (p_hold) else $error("result word changed while stalled");

    // the unused status code never appears
    property p_status;
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[9:8] != 2'd3);
    endproperty
    a_status: assert property (p_status) else $error("illegal status code");

    // removal and read data only come with an ok status
    property p_removed;
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[10] || (m_tdata[7:0] != 8'd0)))
            |-> (m_tdata[9:8] == stkrm_pkg::ST_OK);
    endproperty
    a_removed: assert property (p_removed) else $error("data or removed on an error");

    // count never goes past the stack depth
    property p_count;
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((DEPTH > 63) || (m_tdata[16:11] <= 6'(DEPTH)));
    endproperty
    a_count: assert property (p_count) else $error("count beyond depth");

    // a full report only follows a full stack
    property p_full;
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[9:8] == stkrm_pkg::ST_FULL))
            |-> ((DEPTH > 63) || (m_tdata[16:11] == 6'(DEPTH)));
    endproperty
    a_full: assert property (p_full) else $error("full status below depth");

endmodule

bind stack_with_remove_by_value_unit stkrm_chk #(.DEPTH(DEPTH)) u_stkrm_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/stack_with_remove_by_value_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_with_remove_by_value_checker
// Watches both streams of the byte stack, keeps its own copy of the stack,
// works out the result word for every command word taken and compares each
// result word field by field with the oldest one still owed.
// ----------------------------------------------------------------------------
module stack_with_remove_by_value_checker
    import stkrm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // [1:0] cmd, [9:2] value
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] data, [9:8] status, [10] removed, [16:11] count
    input  logic [M_TDATA_W-1:0]  m_tdata,
    output int unsigned           mismatches,
    output int unsigned           results_owed
);

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
        logic       removed;
        logic [5:0] count;
    } stack_result_t;

    logic [7:0]    stack_cells [DEPTH];
    int            stack_fill;
    stack_result_t owed_results [$];

    initial begin
        mismatches   = 0;
        results_owed = 0;
        stack_fill   = 0;
    end

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: stack result %s mismatch, got %0h, want %0h", $realtime, field,
                 got, want);
        mismatches++;
    endtask

    // applies one command to the local stack and returns the word it should give
    function automatic stack_result_t stack_apply(input cmd_t op, input logic [7:0] value);
        stack_result_t res;
        logic          found;
        res   = '0;
        found = 1'b0;
        res.status = ST_OK;
        case (op)
            CMD_PUSH: begin
                if (stack_fill >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    stack_cells[stack_fill] = value;
                    stack_fill++;
                end
            end
            CMD_POP, CMD_PEEK: begin
                if (stack_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.data = stack_cells[stack_fill - 1];
                    if (op == CMD_POP) begin
                        stack_fill--;
                    end
                end
            end
            default: begin
                // topmost match goes, everything above it slides down one cell
                for (int i = stack_fill - 1; i >= 0; i--) begin
                    if (!found && stack_cells[i] == value) begin
                        found = 1'b1;
                        for (int k = i; k + 1 < stack_fill; k++) begin
                            stack_cells[k] = stack_cells[k + 1];
                        end
                        stack_fill--;
                    end
                end
                res.removed = found;
            end
        endcase
        res.count = stack_fill[5:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        stack_result_t seen;
        stack_result_t want;
        if (!aresetn) begin
            stack_fill = 0;
            owed_results.delete();
            results_owed = 0;
        end else begin
            // predict before checking so a same-edge result would still line up
            if (s_tvalid && s_tready) begin
                owed_results.push_back(stack_apply(cmd_t'(s_tdata[1:0]), s_tdata[9:2]));
            end
            if (m_tvalid && m_tready) begin
                seen.data    = m_tdata[7:0];
                seen.status  = m_tdata[9:8];
                seen.removed = m_tdata[10];
                seen.count   = m_tdata[16:11];
                if (owed_results.size() == 0) begin
                    report_mismatch("unexpected word", seen.data, 8'h00);
                end else begin
                    want = owed_results.pop_front();
                    if (seen.data !== want.data) begin
                        report_mismatch("data", seen.data, want.data);
                    end
                    if (seen.status !== want.status) begin
                        report_mismatch("status", {6'b0, seen.status}, {6'b0, want.status});
                    end
                    if (seen.removed !== want.removed) begin
                        report_mismatch("removed", {7'b0, seen.removed}, {7'b0, want.removed});
                    end
                    if (seen.count !== want.count) begin
                        report_mismatch("count", {2'b0, seen.count}, {2'b0, want.count});
                    end
                end
            end
            results_owed = owed_results.size();
        end
    end

endmodule

// ===== tb/tb_stack_with_remove_by_value_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_with_remove_by_value_unit
// Drives push, pop, peek and remove words into the byte stack: a directed
// opening over the empty, duplicate and no-match cases, then random phases
// that fill, prune and drain the stack with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_stack_with_remove_by_value_unit;
    import stkrm_pkg::*;

    localparam int unsigned ITEM_TARGET = 1900;
    localparam int unsigned CALM_ITEMS  = 150;
    localparam int unsigned LONG_HOLD   = 250;

    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_PRUNE,
        MODE_DRAIN,
        MODE_MIXED
    } traffic_mode_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int unsigned mismatches;
    int unsigned results_owed;
    int unsigned words_sent   = 0;
    logic        calm_tail    = 1'b0;
    logic        hold_off_req = 1'b0;
    logic [7:0]  value_pool [4];

    always #5 aclk = ~aclk;

    stack_with_remove_by_value_unit #(
        .DEPTH (DEPTH_DEFAULT)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    stack_with_remove_by_value_checker #(
        .DEPTH (DEPTH_DEFAULT)
    ) i_stack_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    // offers one word and holds it until taken, then maybe idles a while
    task automatic send_word(input cmd_t op, input logic [7:0] value);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, value, op};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        words_sent++;
        if (!calm_tail && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'($urandom);
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic drain_pause();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (results_owed == 0);
        @(posedge aclk);
    endtask

    function automatic cmd_t pick_command(input traffic_mode_t mode);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:  return roll < 70 ? CMD_PUSH : roll < 80 ? CMD_POP :
                               roll < 90 ? CMD_PEEK : CMD_REMOVE;
            MODE_PRUNE: return roll < 45 ? CMD_PUSH : roll < 50 ? CMD_POP :
                               roll < 60 ? CMD_PEEK : CMD_REMOVE;
            MODE_DRAIN: return roll < 15 ? CMD_PUSH : roll < 65 ? CMD_POP :
                               roll < 80 ? CMD_PEEK : CMD_REMOVE;
            default:    return cmd_t'(roll[1:0]);
        endcase
    endfunction

    // half the values come from a small pool so removes find duplicates
    function automatic logic [7:0] pick_value();
        if ($urandom_range(0, 1) == 1) begin
            return value_pool[$urandom_range(0, 3)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // receiver: random back-pressure, one long hold-off on request
    initial begin : result_side
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0) begin
                    repeat ($urandom_range(40, 100)) @(posedge aclk);
                end else begin
                    repeat ($urandom_range(1, 24)) @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        traffic_mode_t mode;
        int unsigned   phase;
        int unsigned   phase_len;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty stack, duplicates, no match, bottom and top removal
        send_word(CMD_POP,    8'h00);
        send_word(CMD_PEEK,   8'hff);
        send_word(CMD_REMOVE, 8'h00);
        send_word(CMD_PUSH,   8'h00);
        send_word(CMD_PUSH,   8'hff);
        send_word(CMD_PUSH,   8'h5a);
        send_word(CMD_PUSH,   8'hff);
        send_word(CMD_PUSH,   8'ha5);
        send_word(CMD_PEEK,   8'h00);
        send_word(CMD_REMOVE, 8'hff);
        send_word(CMD_REMOVE, 8'h77);
        send_word(CMD_POP,    8'h00);
        send_word(CMD_POP,    8'h00);
        send_word(CMD_REMOVE, 8'h00);
        send_word(CMD_PEEK,   8'h00);
        send_word(CMD_POP,    8'h00);
        send_word(CMD_POP,    8'h00);
        send_word(CMD_PUSH,   8'h80);
        send_word(CMD_PUSH,   8'h01);
        send_word(CMD_REMOVE, 8'h01);
        send_word(CMD_REMOVE, 8'h80);
        send_word(CMD_PEEK,   8'h00);

        phase = 0;
        while (words_sent < ITEM_TARGET) begin
            case (phase)
                0:       mode = MODE_FILL;
                1:       mode = MODE_PRUNE;
                2:       mode = MODE_DRAIN;
                default: mode = traffic_mode_t'($urandom_range(0, 3));
            endcase
            for (int p = 0; p < 4; p++) begin
                value_pool[p] = 8'($urandom);
            end
            // long receiver stall so the stack stalls its input
            if (phase == 2) begin
                hold_off_req = 1'b1;
            end
            if (phase % 5 == 4) begin
                drain_pause();
            end
            phase_len = (mode == MODE_FILL) ? $urandom_range(80, 120) : $urandom_range(40, 100);
            for (int n = 0; n < phase_len && words_sent < ITEM_TARGET; n++) begin
                calm_tail = (words_sent >= ITEM_TARGET - CALM_ITEMS);
                send_word(pick_command(mode), pick_value());
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (results_owed == 0);
        repeat (4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_stack_with_remove_by_value_unit passed");
        end else begin
            $display("tb_stack_with_remove_by_value_unit failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb_stack_with_remove_by_value_unit failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/stkrm_pkg.sv
rtl/core/stkrm_cell.sv
rtl/core/stack_with_remove_by_value_unit.sv
rtl/core/stkrm_chk.sv
tb/stack_with_remove_by_value_checker.sv
tb/tb_stack_with_remove_by_value_unit.sv
